// ----- rtl/qsa_pkg.sv -----
`timescale 1ns / 1ps
package qsa_pkg;
	localparam int CB = 16;
	localparam int FB = 14;
	localparam int QW = 16;
	localparam int L2W = 2 * CB + 2;
	localparam int NW = FB + 2;
	localparam int DW = 2 * FB + 4;
	localparam int KB = 2 * FB + 2;
	localparam int RW = L2W + 2;

	typedef struct packed {
		logic signed [NW-1:0] n0, n1, n2;
		logic signed [NW-1:0] m0, m1, m2;
		logic zero;
	} qsa_norm_t;
endpackage

// ----- rtl/qsa_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring step of floor(num * 2^k / den) for several lanes at once.
module qsa_div_cell #(
	parameter int LANES = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [LANES-1:0][qsa_pkg::RW-1:0] r_in,
	input  logic [LANES-1:0][qsa_pkg::KB:0] q_in,
	input  logic [LANES-1:0][qsa_pkg::RW-1:0] d_in,
	output logic v_out,
	output logic [LANES-1:0][qsa_pkg::RW-1:0] r_out,
	output logic [LANES-1:0][qsa_pkg::KB:0] q_out,
	output logic [LANES-1:0][qsa_pkg::RW-1:0] d_out
);
	import qsa_pkg::*;
	logic [LANES-1:0][RW-1:0] r_d;
	logic [LANES-1:0][KB:0] q_d;

	// compare 2r against den, subtract or keep; a remainder that already
	// reached den holds and sets every quotient bit
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (r_in[i] >= d_in[i]) begin
				r_d[i] = r_in[i];
				q_d[i] = {q_in[i][KB-1:0], 1'b1};
			end else if (r_in[i] >= d_in[i] - r_in[i]) begin
				r_d[i] = r_in[i] - (d_in[i] - r_in[i]);
				q_d[i] = {q_in[i][KB-1:0], 1'b1};
			end else begin
				r_d[i] = {r_in[i][RW-2:0], 1'b0};
				q_d[i] = {q_in[i][KB-1:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= r_d;
			q_out <= q_d;
			d_out <= d_in;
		end
	end
endmodule

// ----- rtl/qsa_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One digit step of the bit-by-bit floor square root, for several lanes.
module qsa_sqrt_cell #(
	parameter int LANES = 6,
	parameter int XW = 32,
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [LANES-1:0][XW-1:0] x_in,
	input  logic [LANES-1:0][XW-1:0] s_in,
	output logic v_out,
	output logic [LANES-1:0][XW-1:0] x_out,
	output logic [LANES-1:0][XW-1:0] s_out
);
	localparam int BP = XW - 2 - 2 * STEP;
	logic [XW-1:0] bitv;
	logic [LANES-1:0][XW-1:0] x_d, s_d;

	assign bitv = {{(XW-1){1'b0}}, 1'b1} << BP;

	// trial subtract of res + bit
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (x_in[i] >= s_in[i] + bitv) begin
				x_d[i] = x_in[i] - (s_in[i] + bitv);
				s_d[i] = (s_in[i] >> 1) + bitv;
			end else begin
				x_d[i] = x_in[i];
				s_d[i] = s_in[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= x_d;
			s_out <= s_d;
		end
	end
endmodule

// ----- rtl/qsa_normalize.sv -----
`timescale 1ns / 1ps
// Normalizes lanes of signed components: divider chain then sqrt chain.
// Sideband data rides along unchanged through a matching delay line.
module qsa_normalize #(
	parameter int LANES = 6,
	parameter int SBW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [LANES-1:0][qsa_pkg::RW-1:0] num_in,
	input  logic [LANES-1:0][qsa_pkg::RW-1:0] den_in,
	input  logic [LANES-1:0] neg_in,
	input  logic [SBW-1:0] sb_in,
	output logic v_out,
	output logic [LANES-1:0][qsa_pkg::NW-1:0] mag_out,
	output logic [LANES-1:0] neg_out,
	output logic [SBW-1:0] sb_out
);
	import qsa_pkg::*;
	localparam int XW = KB + 2;
	localparam int SQ = XW / 2;
	localparam int DEPTH = KB + SQ;

	logic [KB:0] vd;
	logic [KB:0][LANES-1:0][RW-1:0] rr, dd;
	logic [KB:0][LANES-1:0][KB:0] qq;
	logic [SQ:0] vs;
	logic [SQ:0][LANES-1:0][XW-1:0] xx, ss;
	logic [DEPTH-1:0][SBW+LANES-1:0] sb_q;

	// seed: num >= den saturates to 2^k - 1, which rounds like 2^k after the root
	always_comb begin
		vd[0] = v_in;
		for (int i = 0; i < LANES; i++) begin
			rr[0][i] = num_in[i];
			dd[0][i] = den_in[i];
			qq[0][i] = '0;
		end
	end

	for (genvar g = 0; g < KB; g++) begin : g_div
		qsa_div_cell #(.LANES(LANES)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .v_in(vd[g]),
			.r_in(rr[g]), .q_in(qq[g]), .d_in(dd[g]),
			.v_out(vd[g+1]), .r_out(rr[g+1]), .q_out(qq[g+1]), .d_out(dd[g+1])
		);
	end

	// quotient (2^k - 1 when numerator reached denominator)
	always_comb begin
		vs[0] = vd[KB];
		for (int i = 0; i < LANES; i++) begin
			ss[0][i] = '0;
			if (dd[KB][i] == '0) begin
				xx[0][i] = '0;
			end else if (qq[KB][i] == '0 && rr[KB][i] == '0) begin
				xx[0][i] = '0;
			end else begin
				xx[0][i] = XW'(qq[KB][i]);
			end
		end
	end

	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		qsa_sqrt_cell #(.LANES(LANES), .XW(XW), .STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .v_in(vs[g]),
			.x_in(xx[g]), .s_in(ss[g]),
			.v_out(vs[g+1]), .x_out(xx[g+1]), .s_out(ss[g+1])
		);
	end

	assign v_out = vs[SQ];
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag_out[i] = NW'((ss[SQ][i] + 1'b1) >> 1);
		end
	end

	// sideband delay line
	always_ff @(posedge clk) begin
		if (en) begin
			sb_q[0] <= {sb_in, neg_in};
			for (int j = 1; j < DEPTH; j++) begin
				sb_q[j] <= sb_q[j-1];
			end
		end
	end
	assign {sb_out, neg_out} = sb_q[DEPTH-1];
endmodule

// ----- rtl/quat_shortest_arc.sv -----
`timescale 1ns / 1ps
// Shortest-arc quaternion from a source and a target vector, one beat per cycle.
// Both vectors are normalized, then w = sqrt((1+dot)/2) and xyz = cross/(2w);
// nearly opposite vectors give a half-turn about an axis orthogonal to the
// source, and a zero vector gives the identity with zero_length set. The result
// passes through three chains of divider and square root cells (vector
// normalization, w with half-turn axis normalization, and the quotient) before
// out_valid. The block accepts a new beat every cycle; a result waiting under
// out_stall freezes the whole pipeline and stalls the input.
module quat_shortest_arc (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [9:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [qsa_pkg::CB-1:0] src_x,
	input  logic signed [qsa_pkg::CB-1:0] src_y,
	input  logic signed [qsa_pkg::CB-1:0] src_z,
	input  logic signed [qsa_pkg::CB-1:0] dst_x,
	input  logic signed [qsa_pkg::CB-1:0] dst_y,
	input  logic signed [qsa_pkg::CB-1:0] dst_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	output logic half_turn,
	output logic zero_length
);
	import qsa_pkg::*;
	localparam int F = FB;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< F;

	logic [9:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 10'd1;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// whole pipe advances when the output register can take a beat
	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	logic go;
	assign go = in_valid && adv;

	// stage 1: magnitudes and squared lengths
	logic [5:0][RW-1:0] sq_s1;
	logic [5:0] ng_s1;
	logic [RW-1:0] la_s1, lb_s1;
	logic v_s1;
	logic signed [CB-1:0] cin [6];
	logic [CB:0] mg [6];
	logic [2*CB+1:0] sqm [6];
	assign cin = '{src_x, src_y, src_z, dst_x, dst_y, dst_z};

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			mg[i] = cin[i][CB-1] ? -{cin[i][CB-1], cin[i]} : {1'b0, cin[i]};
			sqm[i] = mg[i] * mg[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= go;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				ng_s1[i] <= cin[i][CB-1];
				sq_s1[i] <= RW'(sqm[i]);
			end
		end
	end
	always_comb begin
		la_s1 = sq_s1[0] + sq_s1[1] + sq_s1[2];
		lb_s1 = sq_s1[3] + sq_s1[4] + sq_s1[5];
	end

	// stage 2: register squared components and lengths
	logic [5:0][RW-1:0] num_s2, den_s2;
	logic [5:0] ng_s2;
	logic zero_s2, v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				num_s2[i] <= sq_s1[i];
				den_s2[i] <= (i < 3) ? la_s1 : lb_s1;
			end
			ng_s2 <= ng_s1;
			zero_s2 <= (la_s1 == '0) || (lb_s1 == '0);
		end
	end

	// normalization chain A
	logic va;
	logic [5:0][NW-1:0] na;
	logic [5:0] nga;
	logic za;
	qsa_normalize #(.LANES(6), .SBW(1)) u_norm_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_in(v_s2),
		.num_in(num_s2), .den_in(den_s2), .neg_in(ng_s2), .sb_in(zero_s2),
		.v_out(va), .mag_out(na), .neg_out(nga), .sb_out(za)
	);

	// stage 3: signed normalized components and products
	logic signed [NW:0] n_s3 [6];
	logic signed [DW-1:0] pd_s3 [9];
	logic zero_s3, v_s3;
	logic [9:0] thr_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= va;
	end
	logic signed [NW:0] nn [6];
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			nn[i] = nga[i] ? -$signed({1'b0, na[i]}) : $signed({1'b0, na[i]});
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) n_s3[i] <= nn[i];
			pd_s3[0] <= DW'(nn[0] * nn[3]);
			pd_s3[1] <= DW'(nn[1] * nn[4]);
			pd_s3[2] <= DW'(nn[2] * nn[5]);
			pd_s3[3] <= DW'(nn[1] * nn[5]);
			pd_s3[4] <= DW'(nn[2] * nn[4]);
			pd_s3[5] <= DW'(nn[2] * nn[3]);
			pd_s3[6] <= DW'(nn[0] * nn[5]);
			pd_s3[7] <= DW'(nn[0] * nn[4]);
			pd_s3[8] <= DW'(nn[1] * nn[3]);
			zero_s3 <= za;
			thr_s3 <= thr_q;
		end
	end

	// stage 4: dot+1, cross, case decision, half-turn axis pair
	logic signed [DW-1:0] dp1, cr [3];
	logic signed [DW-1:0] thr_full;
	logic ut;
	logic signed [NW:0] pp, rp;
	logic [1:0] sel;
	always_comb begin
		dp1 = (ONE <<< F) + pd_s3[0] + pd_s3[1] + pd_s3[2];
		cr[0] = pd_s3[3] - pd_s3[4];
		cr[1] = pd_s3[5] - pd_s3[6];
		cr[2] = pd_s3[7] - pd_s3[8];
		thr_full = DW'({thr_s3, {(2 * F - 14){1'b0}}});
		ut = (dp1 <= 0) || (dp1 < thr_full);
		if (DW'(n_s3[0] < 0 ? -n_s3[0] : n_s3[0]) * 5 < 3 * ONE) begin
			sel = 2'd0; pp = n_s3[2]; rp = -n_s3[1];
		end else if (DW'(n_s3[1] < 0 ? -n_s3[1] : n_s3[1]) * 5 < 3 * ONE) begin
			sel = 2'd1; pp = -n_s3[2]; rp = n_s3[0];
		end else begin
			sel = 2'd2; pp = n_s3[1]; rp = -n_s3[0];
		end
	end

	logic signed [DW-1:0] dp1_s4, cr_s4 [3];
	logic [RW-1:0] pq_s4, rq_s4;
	logic pn_s4, rn_s4, ut_s4, zero_s4, v_s4;
	logic [1:0] sel_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dp1_s4 <= dp1;
			for (int i = 0; i < 3; i++) cr_s4[i] <= cr[i];
			pn_s4 <= pp < 0;
			rn_s4 <= rp < 0;
			pq_s4 <= RW'(pp * pp);
			rq_s4 <= RW'(rp * rp);
			ut_s4 <= ut;
			sel_s4 <= sel;
			zero_s4 <= zero_s3;
		end
	end

	// chain B lanes: axis p, axis r; plus w sqrt via 2*dp1 as a lane
	// w = (isqrt(2*dp1)+1)>>1 = norm rule with num = dp1, den = 2^(2F+1):
	// num*2^k/den = 2*dp1 exactly when den = 2^(k-1).
	logic [2:0][RW-1:0] numb, denb;
	logic [2:0] ngb;
	always_comb begin
		numb[0] = pq_s4;
		numb[1] = rq_s4;
		denb[0] = pq_s4 + rq_s4;
		denb[1] = pq_s4 + rq_s4;
		numb[2] = dp1_s4 <= 0 ? '0 : RW'(dp1_s4);
		denb[2] = RW'(1) << (KB - 1);
		ngb = {1'b0, rn_s4, pn_s4};
	end
	localparam int SB2 = 3 * DW + 4;
	logic vb;
	logic [2:0][NW-1:0] nb;
	logic [2:0] ngo;
	logic [SB2-1:0] sbo;
	qsa_normalize #(.LANES(3), .SBW(SB2)) u_norm_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_in(v_s4),
		.num_in(numb), .den_in(denb), .neg_in(ngb),
		.sb_in({cr_s4[0], cr_s4[1], cr_s4[2], ut_s4, sel_s4, zero_s4}),
		.v_out(vb), .mag_out(nb), .neg_out(ngo), .sb_out(sbo)
	);
	logic signed [DW-1:0] crb [3];
	logic utb, zb;
	logic [1:0] selb;
	assign {crb[0], crb[1], crb[2], utb, selb, zb} = sbo;

	// stage 5: quotient lanes |C|+w over 2w, w saturates to one
	logic [2:0][RW-1:0] numc, denc;
	logic [2:0] ngc;
	logic [NW-1:0] w5;
	always_comb begin
		w5 = nb[2] > NW'(ONE) ? NW'(ONE) : nb[2];
		for (int i = 0; i < 3; i++) begin
			numc[i] = RW'(crb[i] < 0 ? -crb[i] : crb[i]) + RW'(nb[2]);
			denc[i] = RW'(nb[2]) << 1;
			ngc[i] = crb[i] < 0;
		end
	end
	// integer divide via fraction cells: den scaled up by 2^(F+1), quotient
	// shifted back down; a ratio beyond that range saturates and clamps to one
	localparam int SB3 = 2 * NW + 3 + 2 + NW;
	logic [2:0][RW-1:0] numc2, denc2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			numc2[i] = numc[i];
			denc2[i] = denc[i] << (KB - 2 * F - 2 + F + 1);
		end
	end
	logic [2:0][KB:0] q_q;
	logic vq;
	logic [KB:0] vdc;
	logic [KB:0][2:0][RW-1:0] rc, dc;
	logic [KB:0][2:0][KB:0] qc;
	always_comb begin
		vdc[0] = vb;
		for (int i = 0; i < 3; i++) begin
			rc[0][i] = numc2[i];
			dc[0][i] = denc2[i];
			qc[0][i] = '0;
		end
	end
	for (genvar g = 0; g < KB; g++) begin : g_qdiv
		qsa_div_cell #(.LANES(3)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .v_in(vdc[g]),
			.r_in(rc[g]), .q_in(qc[g]), .d_in(dc[g]),
			.v_out(vdc[g+1]), .r_out(rc[g+1]), .q_out(qc[g+1]), .d_out(dc[g+1])
		);
	end
	assign vq = vdc[KB];
	assign q_q = qc[KB];

	logic [KB-1:0][SB3-1:0] sbq;
	always_ff @(posedge clk) begin
		if (adv) begin
			sbq[0] <= {nb[0], nb[1], ngo[0], ngo[1], ngc[0], ngc[1], ngc[2], w5};
			for (int j = 1; j < KB; j++) sbq[j] <= sbq[j-1];
		end
	end
	logic [KB-1:0][3:0] sbf;
	always_ff @(posedge clk) begin
		if (adv) begin
			sbf[0] <= {utb, selb, zb};
			for (int j = 1; j < KB; j++) sbf[j] <= sbf[j-1];
		end
	end
	logic [NW-1:0] pm, rm, wq;
	logic pneg, rneg;
	logic [2:0] cneg;
	logic uf, zf;
	logic [1:0] sf;
	assign {pm, rm, pneg, rneg, cneg, wq} = sbq[KB-1];
	assign {uf, sf, zf} = sbf[KB-1];

	// final assembly
	function automatic logic signed [15:0] sgn(input logic [KB:0] m, input logic n);
		logic [KB:0] s;
		s = m > (KB+1)'(ONE) ? (KB+1)'(ONE) : m;
		return n ? -16'(s) : 16'(s);
	endfunction
	logic signed [15:0] qx, qy, qz, qw;
	logic signed [15:0] ps, rs;
	always_comb begin
		ps = sgn((KB+1)'(pm), pneg);
		rs = sgn((KB+1)'(rm), rneg);
		qx = '0; qy = '0; qz = '0; qw = '0;
		if (zf) begin
			qw = 16'(ONE);
		end else if (uf) begin
			unique case (sf)
				2'd0: begin qy = ps; qz = rs; end
				2'd1: begin qx = ps; qz = rs; end
				default: begin qx = ps; qy = rs; end
			endcase
		end else begin
			qx = sgn(q_q[0] >> (KB - F - 1), cneg[2]);
			qy = sgn(q_q[1] >> (KB - F - 1), cneg[1]);
			qz = sgn(q_q[2] >> (KB - F - 1), cneg[0]);
			qw = 16'(wq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vq;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
			half_turn <= uf && !zf;
			zero_length <= zf;
		end
	end
endmodule

// ----- test/tb_quat_shortest_arc.sv -----
`timescale 1ns / 1ps
module tb_quat_shortest_arc;
	localparam int CB = 16;
	localparam int FB = 14;
	localparam longint ONE = longint'(1) << FB;
	localparam int SETTLE_CYCLES = 250;   // more than the pipeline latency
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_BEATS = 1725;

	typedef enum logic [1:0] {K_BEAT, K_CFG, K_DRAIN} step_kind_e;

	typedef struct {
		step_kind_e kind;
		logic signed [CB-1:0] v [6];
		logic [9:0] thr;
	} step_t;

	typedef struct {
		logic signed [15:0] q [4];
		logic half;
		logic zero;
	} arc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [9:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] src_x = '0, src_y = '0, src_z = '0;
	logic signed [CB-1:0] dst_x = '0, dst_y = '0, dst_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic half_turn, zero_length;

	quat_shortest_arc dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.src_x(src_x), .src_y(src_y), .src_z(src_z),
		.dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.half_turn(half_turn), .zero_length(zero_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	step_t pend_q [$];
	arc_t arc_q [$];
	logic [9:0] thr_cur = 10'd1;
	int fails = 0;
	int n_sent = 0;
	int n_recv = 0;
	int n_half = 0;
	int n_zero = 0;
	int n_cfg = 0;

	// ---------------- arc predictor ----------------
	function automatic longint isqrt_fl(longint x);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(num * 2^k / den), num <= den
	function automatic longint frac_div(longint num, longint den, int k);
		longint q, r;
		q = 0;
		r = num;
		if (num >= den) return longint'(1) << k;
		for (int i = 0; i < k; i++) begin
			q = q << 1;
			if (r >= den - r) begin
				r = r - (den - r);
				q = q | 1;
			end else begin
				r = r << 1;
			end
		end
		return q;
	endfunction

	function automatic longint absl(longint c);
		return c < 0 ? -c : c;
	endfunction

	function automatic longint unit_comp(longint c, longint len2);
		longint m, s;
		m = absl(c);
		if (len2 == 0 || m == 0) return 0;
		s = (isqrt_fl(frac_div(m * m, len2, 2 * FB + 2)) + 1) >> 1;
		return c < 0 ? -s : s;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic arc_t shortest_arc(logic signed [CB-1:0] v [6], logic [9:0] thr);
		arc_t r;
		longint a [3], b [3], n [3], m [3], q [4], cr [3];
		longint la, lb, dp1, p, s, w, mv;
		int px, sx;
		q = '{0, 0, 0, 0};
		r.half = 1'b0;
		r.zero = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'(v[i]);
			b[i] = longint'(v[i + 3]);
		end
		la = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		lb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
		if (la == 0 || lb == 0) begin
			r.zero = 1'b1;
			q[3] = ONE;
		end else begin
			for (int i = 0; i < 3; i++) begin
				n[i] = unit_comp(a[i], la);
				m[i] = unit_comp(b[i], lb);
			end
			dp1 = (longint'(1) << (2 * FB)) + n[0] * m[0] + n[1] * m[1] + n[2] * m[2];
			if (dp1 <= 0 || dp1 < (longint'(thr) << (2 * FB - 14))) begin
				// opposite vectors: half-turn about an axis orthogonal to the source
				r.half = 1'b1;
				if (absl(n[0]) * 5 < 3 * ONE) begin
					p = n[2]; s = -n[1]; px = 1; sx = 2;
				end else if (absl(n[1]) * 5 < 3 * ONE) begin
					p = -n[2]; s = n[0]; px = 0; sx = 2;
				end else begin
					p = n[1]; s = -n[0]; px = 0; sx = 1;
				end
				la = p * p + s * s;
				q[px] = unit_comp(p, la);
				q[sx] = unit_comp(s, la);
			end else begin
				w = (isqrt_fl(2 * dp1) + 1) >> 1;
				cr[0] = n[1] * m[2] - n[2] * m[1];
				cr[1] = n[2] * m[0] - n[0] * m[2];
				cr[2] = n[0] * m[1] - n[1] * m[0];
				for (int i = 0; i < 3; i++) begin
					mv = (absl(cr[i]) + w) / (2 * w);
					if (mv > ONE) mv = ONE;
					q[i] = cr[i] < 0 ? -mv : mv;
				end
				q[3] = w;
			end
		end
		for (int i = 0; i < 4; i++) r.q[i] = 16'(clamp_one(q[i]));
		return r;
	endfunction

	// ---------------- stimulus ----------------
	task automatic add_beat(int ax, int ay, int az, int bx, int by, int bz);
		step_t s;
		s.kind = K_BEAT;
		s.thr = '0;
		s.v[0] = CB'(ax); s.v[1] = CB'(ay); s.v[2] = CB'(az);
		s.v[3] = CB'(bx); s.v[4] = CB'(by); s.v[5] = CB'(bz);
		pend_q.push_back(s);
	endtask

	task automatic add_marker(step_kind_e k, logic [9:0] thr);
		step_t s;
		s.kind = k;
		s.thr = thr;
		for (int i = 0; i < 6; i++) s.v[i] = '0;
		pend_q.push_back(s);
	endtask

	function automatic int rnd_comp();
		int c;
		c = $signed(16'($urandom));
		return c >>> $urandom_range(0, 15);
	endfunction

	function automatic int pick_edge();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return -1;
			3: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic int wiggle(int c, int span);
		int r;
		r = c + $urandom_range(0, 2 * span) - span;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	task automatic add_random_beat();
		int a [3], b [3], k;
		for (int i = 0; i < 3; i++) a[i] = rnd_comp();
		k = $urandom_range(0, 19);
		if (k < 5) begin
			for (int i = 0; i < 3; i++) b[i] = rnd_comp();
		end else if (k < 10) begin
			// nearly opposite, noise on the target
			for (int i = 0; i < 3; i++) b[i] = wiggle(-(a[i] >>> 1), $urandom_range(0, 40));
		end else if (k < 12) begin
			for (int i = 0; i < 3; i++) b[i] = wiggle(a[i], $urandom_range(0, 40));
		end else if (k < 15) begin
			// one dominant source axis, to steer the half-turn axis choice
			a[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 30000 : -30000;
			for (int i = 0; i < 3; i++) b[i] = wiggle(-a[i], $urandom_range(0, 200));
		end else if (k < 17) begin
			for (int i = 0; i < 3; i++) begin
				a[i] = pick_edge();
				b[i] = pick_edge();
			end
		end else if (k < 18) begin
			for (int i = 0; i < 3; i++) b[i] = rnd_comp();
			if ($urandom_range(0, 1)) a = '{0, 0, 0};
			else b = '{0, 0, 0};
		end else begin
			for (int i = 0; i < 3; i++) begin
				a[i] = $signed(16'($urandom));
				b[i] = $signed(16'($urandom));
			end
		end
		add_beat(a[0], a[1], a[2], b[0], b[1], b[2]);
	endtask

	initial begin
		// directed: zero vectors, extremes, every axis choice, aligned and square
		add_beat(0, 0, 0, 1, 2, 3);
		add_beat(1, 2, 3, 0, 0, 0);
		add_beat(0, 0, 0, 0, 0, 0);
		add_beat(32767, 32767, 32767, -32768, -32768, -32768);
		add_beat(-32768, -32768, -32768, 32767, 32767, 32767);
		add_beat(1, 0, 0, -1, 0, 0);
		add_beat(0, 1, 0, 0, -1, 0);
		add_beat(0, 0, -1, 0, 0, 1);
		add_beat(1, 1, 0, -1, -1, 0);
		add_beat(3, 4, 0, -3, -4, 0);
		add_beat(5, 5, 5, 5, 5, 5);
		add_beat(-32768, 0, 0, -32768, 0, 0);
		add_beat(1, 0, 0, 0, 1, 0);
		add_beat(32767, 0, 0, 0, 0, -32768);
		add_beat(-32768, 0, 0, 32767, 1, 0);
		add_beat(-32768, 32767, -1, 32767, -32768, 1);
		add_beat(100, -7, 3, -100, 7, -2);
		add_beat(1, -1, 1, -1, 1, -1);
		add_marker(K_CFG, 10'd0);
		add_beat(1, 0, 0, -1, 0, 0);
		add_beat(3, 4, 0, -3, -4, 0);
		add_beat(100, -7, 3, -100, 7, -2);
		add_marker(K_CFG, 10'd1023);
		add_beat(100, -7, 3, -100, 7, -2);
		add_beat(1000, 20, 0, -1000, -5, 40);
		// random phases at several threshold settings
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == 350) add_marker(K_CFG, 10'd0);
			if (i == 700) add_marker(K_DRAIN, '0);
			if (i == 900) add_marker(K_CFG, 10'($urandom_range(2, 1022)));
			if (i == 1300) add_marker(K_CFG, 10'd1);
			add_random_beat();
		end
	end

	// ---------------- driver ----------------
	int gap_left = 0;
	int settle = 0;
	logic take_in, v_nxt, we_nxt;
	step_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			take_in = in_valid && !in_stall;
			v_nxt = in_valid && !take_in;
			we_nxt = 1'b0;
			if (take_in) begin
				arc_q.push_back(shortest_arc('{src_x, src_y, src_z, dst_x, dst_y, dst_z},
					thr_cur));
				n_sent++;
			end
			if (!v_nxt) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() != 0) begin
					cur = pend_q[0];
					if (cur.kind == K_BEAT) begin
						src_x <= cur.v[0]; src_y <= cur.v[1]; src_z <= cur.v[2];
						dst_x <= cur.v[3]; dst_y <= cur.v[4]; dst_z <= cur.v[5];
						v_nxt = 1'b1;
						void'(pend_q.pop_front());
						// a run of back-to-back beats in the middle
						gap_left = (n_sent > 1000 && n_sent < 1150) ? 0 : $urandom_range(0, 3);
					end else if (arc_q.size() == 0 && !take_in) begin
						// block idle: wait out the pipeline, then write or resume
						if (settle < SETTLE_CYCLES) begin
							settle++;
						end else begin
							settle = 0;
							void'(pend_q.pop_front());
							if (cur.kind == K_CFG) begin
								we_nxt = 1'b1;
								cfg_data <= cur.thr;
								thr_cur = cur.thr;
								n_cfg++;
							end
						end
					end
				end
			end
			in_valid <= v_nxt;
			cfg_we <= we_nxt;
		end
	end

	// ---------------- monitor ----------------
	int stall_left = 0;
	logic long_hold_done = 1'b0;
	logic take_out;
	arc_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			take_out = out_valid && !out_stall;
			if (take_out) begin
				n_recv++;
				if (arc_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected beat q=(%0d %0d %0d %0d) half=%0b zero=%0b",
						$time, quat_x, quat_y, quat_z, quat_w, half_turn, zero_length);
				end else begin
					want = arc_q.pop_front();
					if (want.half) n_half++;
					if (want.zero) n_zero++;
					if (quat_x !== want.q[0] || quat_y !== want.q[1] ||
						quat_z !== want.q[2] || quat_w !== want.q[3] ||
						half_turn !== want.half || zero_length !== want.zero) begin
						fails++;
						$display("%0t: mismatch beat %0d exp q=(%0d %0d %0d %0d) h=%0b z=%0b",
							$time, n_recv, want.q[0], want.q[1], want.q[2], want.q[3],
							want.half, want.zero);
						$display("%0t:                    act q=(%0d %0d %0d %0d) h=%0b z=%0b",
							$time, quat_x, quat_y, quat_z, quat_w, half_turn, zero_length);
					end
				end
				stall_left = (n_recv > 1050 && n_recv < 1200) ? 0 : $urandom_range(0, 3);
				// one long hold so the pipeline fills and backs up the input
				if (n_recv == 400 && !long_hold_done) begin
					stall_left = HOLD_CYCLES;
					long_hold_done = 1'b1;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $time, arc_q.size());
				$display("tb_quat_shortest_arc failed");
				$finish;
			end
		end
	end

	// ---------------- reset and end of run ----------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pend_q.size() != 0 || in_valid || arc_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d beats, %0d results (%0d half-turn, %0d zero-length)",
			n_sent, n_recv, n_half, n_zero);
		$display("threshold written %0d times, including 0 and 1023", n_cfg);
		if (fails == 0 && arc_q.size() == 0) begin
			$display("tb_quat_shortest_arc passed");
		end else begin
			$display("tb_quat_shortest_arc failed");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/qsa_pkg.sv
rtl/qsa_div_cell.sv
rtl/qsa_sqrt_cell.sv
rtl/qsa_normalize.sv
rtl/quat_shortest_arc.sv
test/tb_quat_shortest_arc.sv
